// File: rtl/mmsr_pkg.sv
// Shared constants, types and helpers for the multi-motor step ramp framer.
package mmsr_pkg;

    localparam int MAX_MOTORS     = 16;
    localparam int POSITION_LIMIT = 2000;

    localparam int SLOT_W  = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int CNT_W   = $clog2(MAX_MOTORS + 1);
    localparam int GOAL_W  = $clog2(POSITION_LIMIT + 1);
    localparam int POS_W   = 12;
    localparam int ID_W    = 8;
    localparam int BYTE_W  = 8;
    localparam int HDR_LEN = 5;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
    localparam logic [BYTE_W-1:0] BCAST_ID    = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_WRITE   = 8'hF2;

    localparam logic OPC_LOAD    = 1'b0;
    localparam logic OPC_TICK    = 1'b1;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
    localparam logic [1:0] REG_FRAME_PERIOD = 2'd1;
    localparam logic [1:0] REG_MOTOR_COUNT  = 2'd2;

    localparam logic [7:0] STEP_SIZE_RESET    = 8'd10;
    localparam logic [7:0] FRAME_PERIOD_RESET = 8'd10;
    localparam logic [4:0] MOTOR_COUNT_RESET  = 5'd1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [GOAL_W-1:0] goal;
        logic [POS_W-1:0]  pos;
    } slot_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [GOAL_W-1:0] next_pos;
        logic              near;
    } slot_eval_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NOTICE,
        ST_HEADER,
        ST_STEP,
        ST_ID,
        ST_LO,
        ST_HI,
        ST_SUM
    } seq_state_t;

    function automatic logic [BYTE_W-1:0] header_byte(input logic [2:0] idx,
                                                      input logic [BYTE_W-1:0] len);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = SYNC_FIRST;
            3'd1:    b = SYNC_SECOND;
            3'd2:    b = len;
            3'd3:    b = BCAST_ID;
            default: b = CMD_WRITE;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/mmsr_slot_store.sv
// Motor slot memory with registered read and the per-slot step arithmetic.
module mmsr_slot_store (
    input  logic                        aclk,
    input  logic                        load_en,
    input  logic [mmsr_pkg::SLOT_W-1:0] load_addr,
    input  mmsr_pkg::slot_entry_t       load_entry,
    input  logic [mmsr_pkg::SLOT_W-1:0] rd_addr,
    input  logic                        commit,
    input  logic [7:0]                  step_size,
    output mmsr_pkg::slot_eval_t        eval
);
    import mmsr_pkg::*;

    slot_entry_t             mem [MAX_MOTORS];
    slot_entry_t             rd_reg;
    logic [SLOT_W-1:0]       rd_addr_reg;

    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_addr;
    slot_entry_t             wr_data;

    logic [POS_W-1:0]        goal_ext;
    logic [POS_W-1:0]        cur;
    logic [POS_W-1:0]        step_ext;
    logic [POS_W-1:0]        mag;
    logic [POS_W-1:0]        dn_pos;
    logic [POS_W-1:0]        next_full;
    logic                    up;

    always_comb begin
        goal_ext = POS_W'(rd_reg.goal);
        cur      = rd_reg.pos;
        step_ext = POS_W'(step_size);
        up       = goal_ext > cur;
        mag      = up ? (goal_ext - cur) : (cur - goal_ext);
        dn_pos   = cur - step_ext;
        if (mag <= step_ext) begin
            next_full = goal_ext;
        end else if (up) begin
            next_full = cur + step_ext;
        end else if (dn_pos > POS_W'(POSITION_LIMIT)) begin
            next_full = POS_W'(POSITION_LIMIT);
        end else begin
            next_full = dn_pos;
        end
        eval.id       = rd_reg.id;
        eval.next_pos = GOAL_W'(next_full);
        eval.near     = mag <= POS_W'(1);
    end

    // one write port: loads and step write-backs never coincide
    always_comb begin
        wr_en   = load_en | commit;
        wr_addr = load_en ? load_addr : rd_addr_reg;
        if (load_en) begin
            wr_data = load_entry;
        end else begin
            wr_data.id   = rd_reg.id;
            wr_data.goal = rd_reg.goal;
            wr_data.pos  = POS_W'(eval.next_pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg      <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

endmodule

// File: rtl/multi_motor_step_ramp_framer.sv
// Top level of the multi-motor step ramp framer: sequencer, registers, output stage.
// A load item, and a tick in a frame wait or with no move, is handled without leaving idle.
// A tick that fires walks the slots once to test arrival (early exit on a moving slot),
// then emits either one notice or a frame of 6+3N bytes, paced by the write-back step of
// the slot memory and by the one-byte output register.
// Reset (aresetn low at a clock edge): sequencer idle, no move, wait 0, registers to defaults.
module multi_motor_step_ramp_framer (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [3:0]  s_slot,
    input  logic [7:0]  s_motor_id,
    input  logic [11:0] s_goal_position,
    input  logic [11:0] s_start_position,
    // result item channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_frame_byte,
    output logic        m_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mmsr_pkg::*;

    // configuration registers
    logic [7:0]          step_size_reg;
    logic [7:0]          frame_period_reg;
    logic [4:0]          motor_count_reg;

    // sequencer state
    seq_state_t          state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [2:0]          hdr_reg, hdr_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          wait_reg, wait_next;
    logic                active_reg, active_next;
    logic [ID_W-1:0]     id_hold_reg, id_hold_next;
    logic [GOAL_W-1:0]   pos_hold_reg, pos_hold_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic                m_kind_reg, m_kind_next;
    logic [7:0]          m_byte_reg, m_byte_next;
    logic                m_last_reg, m_last_next;

    // derived values
    logic [CNT_W-1:0]    n_eff;
    logic [7:0]          frame_len;
    logic [7:0]          step_eff;
    logic                last_slot;
    logic                out_free;
    logic [15:0]         pos_wide;
    logic [GOAL_W-1:0]   goal_sat;
    logic                slot_ok;

    // emission request from the sequencer
    logic                emit;
    logic                emit_kind;
    logic [7:0]          emit_byte;
    logic                emit_last;
    logic                emit_sum;

    // slot memory interface
    logic                load_en;
    logic                commit;
    slot_entry_t         load_entry;
    slot_eval_t          eval;

    logic                cfg_wr;

    // Clamp the motor count into 1..MAX_MOTORS; zero step acts as one.
    always_comb begin
        if (motor_count_reg == 5'd0) begin
            n_eff = CNT_W'(1);
        end else if (int'(motor_count_reg) > MAX_MOTORS) begin
            n_eff = CNT_W'(MAX_MOTORS);
        end else begin
            n_eff = CNT_W'(motor_count_reg);
        end
    end

    assign frame_len = 8'(({2'b00, n_eff} << 1) + {2'b00, n_eff} + (CNT_W + 2)'(1));
    assign step_eff  = (step_size_reg == 8'd0) ? 8'd1 : step_size_reg;
    assign last_slot = (CNT_W'(idx_reg) + CNT_W'(1)) == n_eff;
    assign out_free  = !m_valid_reg || m_ready;
    assign pos_wide  = 16'(pos_hold_reg);

    // Targets beyond the limit saturate on load so a move can always finish.
    assign goal_sat  = (s_goal_position > 12'(POSITION_LIMIT)) ? GOAL_W'(POSITION_LIMIT)
                                                              : GOAL_W'(s_goal_position);
    assign slot_ok   = int'(s_slot) < MAX_MOTORS;

    always_comb begin
        load_entry.id   = s_motor_id;
        load_entry.goal = goal_sat;
        load_entry.pos  = s_start_position;
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state, memory controls and byte emission.
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        hdr_next      = hdr_reg;
        wait_next     = wait_reg;
        active_next   = active_reg;
        id_hold_next  = id_hold_reg;
        pos_hold_next = pos_hold_reg;
        load_en       = 1'b0;
        commit        = 1'b0;
        emit          = 1'b0;
        emit_kind     = KIND_FRAME;
        emit_byte     = 8'd0;
        emit_last     = 1'b0;
        emit_sum      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == OPC_LOAD) begin
                        // store the slot and arm the move; the wait runs on untouched
                        if (slot_ok) begin
                            load_en     = 1'b1;
                            active_next = 1'b1;
                        end
                    end else if (wait_reg != 8'd0) begin
                        wait_next = wait_reg - 8'd1;
                    end else if (active_reg) begin
                        state_next = ST_CHECK;
                        idx_next   = '0;
                    end
                end
            end
            ST_CHECK: begin
                // one slot per cycle; the read of the next slot is issued now
                if (!eval.near) begin
                    state_next = ST_HEADER;
                    idx_next   = '0;
                    hdr_next   = 3'd0;
                end else if (last_slot) begin
                    state_next  = ST_NOTICE;
                    active_next = 1'b0;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_NOTICE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_NOTICE;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HEADER: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = header_byte(hdr_reg, frame_len);
                    // the checksum starts at the length byte
                    emit_sum  = hdr_reg >= 3'd2;
                    if (hdr_reg == 3'(HDR_LEN - 1)) begin
                        state_next = ST_STEP;
                    end else begin
                        hdr_next = hdr_reg + 3'd1;
                    end
                end
            end
            ST_STEP: begin
                // write the stepped position back and hold it for its bytes
                commit        = 1'b1;
                id_hold_next  = eval.id;
                pos_hold_next = eval.next_pos;
                state_next    = ST_ID;
            end
            ST_ID: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = id_hold_reg;
                    emit_sum   = 1'b1;
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = pos_wide[7:0];
                    emit_sum   = 1'b1;
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = pos_wide[15:8];
                    emit_sum  = 1'b1;
                    if (last_slot) begin
                        state_next = ST_SUM;
                    end else begin
                        idx_next   = idx_reg + SLOT_W'(1);
                        state_next = ST_STEP;
                    end
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = sum_reg;
                    emit_last  = 1'b1;
                    wait_next  = frame_period_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checksum accumulator: clear on frame start, add every counted byte.
    always_comb begin
        if (state_reg == ST_CHECK) begin
            sum_next = 8'd0;
        end else if (emit && emit_sum) begin
            sum_next = sum_reg + emit_byte;
        end else begin
            sum_next = sum_reg;
        end
    end

    // Output register: load when free, otherwise drop valid once taken.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_kind_next  = emit_kind;
            m_byte_next  = emit_byte;
            m_last_next  = emit_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_last       = m_last_reg;

    mmsr_slot_store u_slot_store (
        .aclk       (aclk),
        .load_en    (load_en),
        .load_addr  (SLOT_W'(s_slot)),
        .load_entry (load_entry),
        .rd_addr    (idx_next),
        .commit     (commit),
        .step_size  (step_eff),
        .eval       (eval)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            hdr_reg     <= 3'd0;
            wait_reg    <= 8'd0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hdr_reg     <= hdr_next;
            wait_reg    <= wait_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and holding registers
    always_ff @(posedge aclk) begin
        sum_reg      <= sum_next;
        id_hold_reg  <= id_hold_next;
        pos_hold_reg <= pos_hold_next;
        m_kind_reg   <= m_kind_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    // Configuration port: write in the access phase, read back at any time.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg    <= STEP_SIZE_RESET;
            frame_period_reg <= FRAME_PERIOD_RESET;
            motor_count_reg  <= MOTOR_COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_STEP_SIZE:    step_size_reg    <= pwdata[7:0];
                REG_FRAME_PERIOD: frame_period_reg <= pwdata[7:0];
                REG_MOTOR_COUNT:  motor_count_reg  <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_STEP_SIZE:    prdata = 32'(step_size_reg);
            REG_FRAME_PERIOD: prdata = 32'(frame_period_reg);
            REG_MOTOR_COUNT:  prdata = 32'(motor_count_reg);
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/mmsr_checker.sv
// Port-level checks for the multi-motor step ramp framer, bound to the top level.
module mmsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [7:0]  m_frame_byte,
    input logic        m_last
);
    import mmsr_pkg::*;

    // a stalled result item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_last)
                                && $stable(m_kind))
        else $error("result item changed while stalled");

    // a completion notice is a single item with a zero byte
    a_notice_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_NOTICE) |-> m_last && (m_frame_byte == 8'd0))
        else $error("malformed completion notice");

    // no new input item is taken while a frame is still being sent
    a_busy_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input accepted in the middle of a frame");

    // reset empties the output stage
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind multi_motor_step_ramp_framer mmsr_checker u_mmsr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_frame_byte (m_frame_byte),
    .m_last       (m_last)
);
